// ===== design/mmcs_pkg.sv =====
// Shared types and constants for the min-max contrast stretch block.
package mmcs_pkg;

  // Command codes carried on the input channel.
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_OBSERVE = 2'd0;
  localparam cmd_t CMD_FINISH  = 2'd1;
  localparam cmd_t CMD_CONVERT = 2'd2;

  // Result kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_OFFSET = 1'b1;

  localparam int unsigned GAIN_W   = 48;
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [15:0] FS_RESET = 16'd2000;
  localparam int unsigned EXT_INT  = 9999;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MST,
    ST_MUL,
    ST_PUSH
  } mmcs_state_t;

  // Response of the multiply unit.
  typedef struct packed {
    logic        done;
    logic        sat;
    logic [31:0] value;
  } mmcs_mul_rsp_t;

endpackage

// ===== design/mmcs_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface mmcs_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [31:0] sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);
endinterface

interface mmcs_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] value;
  logic              kind;
  logic              saturated;

  modport source (output valid, output value, output kind, output saturated, input ready);
  modport sink   (input valid, input value, input kind, input saturated, output ready);
endinterface

// ===== design/mmcs_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
module mmcs_div
  import mmcs_pkg::*;
#(
  parameter int unsigned QW = 48
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [31:0]   divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int unsigned CW = $clog2(QW + 1);

  logic [QW-1:0] num_r, num_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [31:0]   den_r;
  logic [31:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [32:0]   rem_sh;
  logic          ge;
  logic          last;

  always_comb begin
    rem_sh  = {rem_r, num_r[QW-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
    quo_nxt = {quo_r[QW-2:0], ge};
    num_nxt = {num_r[QW-2:0], 1'b0};
    last    = cnt_r == CW'(QW - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && last;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/mmcs_mul.sv =====
// Gain times difference over three 33x16 passes, then floor shift and clip.
module mmcs_mul
  import mmcs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [GAIN_W-1:0]  gain,
  input  logic signed [32:0] diff,
  output mmcs_mul_rsp_t      rsp
);

  localparam int unsigned AW = GAIN_W + 33;
  localparam logic [AW-1:0] RND = (AW'(1) << FRAC_BITS) - AW'(1);

  logic [32:0]       m_r;
  logic              neg_r;
  logic [GAIN_W-1:0] g_r;
  logic [AW-1:0]     acc_r;
  logic [1:0]        cnt_r;
  logic              run_r;
  logic              fin_r;
  logic              done_r;
  logic              sat_r;
  logic [31:0]       value_r;

  logic [48:0]   prod;
  logic [AW-1:0] acc_nxt;
  logic [AW-1:0] q;
  logic          sat_nxt;
  logic [31:0]   value_nxt;

  always_comb begin
    prod    = 49'(m_r) * 49'(g_r[GAIN_W-1 -: 16]);
    acc_nxt = {acc_r[AW-17:0], 16'b0} + AW'(prod);
    q       = (acc_r + (neg_r ? RND : '0)) >> FRAC_BITS;
    if (neg_r) begin
      sat_nxt   = q > AW'(33'h0_8000_0000);
      value_nxt = sat_nxt ? 32'h8000_0000 : 32'(32'd0 - q[31:0]);
    end else begin
      sat_nxt   = q > AW'(32'h7FFF_FFFF);
      value_nxt = sat_nxt ? 32'h7FFF_FFFF : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin_r;
      fin_r  <= run_r && (cnt_r == 2'd2);
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= diff[32];
      m_r   <= diff[32] ? 33'(~diff + 33'sd1) : 33'(diff);
      g_r   <= gain;
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      g_r   <= {g_r[GAIN_W-17:0], 16'b0};
    end
    if (fin_r) begin
      sat_r   <= sat_nxt;
      value_r <= value_nxt;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.sat   = sat_r;
  assign rsp.value = value_r;

endmodule

// ===== design/min_max_contrast_stretch.sv =====
// Top level of the min-max contrast stretch: extremes, gain and the sequencer.
//
//  channel   dir  signals                              transfer when
//  in_chan   in   command[1:0], sample[31:0]           valid && ready
//  out_chan  out  value[31:0], kind, saturated         valid && ready
//  cfg       in   cfg_we, cfg_wdata[15:0] (full_scale) cfg_we high
//
// An observe item leaves the sequencer idle and ready. Convert and finish items pass
// through ST_MST, ST_MUL, where the multiply unit makes its three 33x16 passes, and
// ST_PUSH, where the output is loaded; a finish over a spread range first waits in
// ST_DIV for the divider, one quotient bit per cycle, which a flat or empty pass skips.
// Reset is synchronous, active low, and needs no clearing pass.
// A stalled result waits in the output register; the next item is still taken.
module min_max_contrast_stretch
  import mmcs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  mmcs_in_if.sink      in_chan,
  mmcs_out_if.source   out_chan,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  localparam int unsigned QW = 16 + 2 * FRAC_BITS;
  localparam int unsigned WW = (QW > GAIN_W) ? QW : GAIN_W;
  localparam logic [63:0] EXT_RAW = 64'(EXT_INT) << FRAC_BITS;
  localparam logic [31:0] EXT_POS =
      (EXT_RAW > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : EXT_RAW[31:0];
  localparam logic [31:0] EXT_NEG =
      (EXT_RAW > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - EXT_RAW);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(FS_RESET) << FRAC_BITS;

  mmcs_state_t state_r, state_nxt;

  logic [15:0]        full_scale_r;
  logic signed [31:0] low_r;
  logic signed [31:0] high_r;
  logic [GAIN_W-1:0]  gain_r;
  logic signed [31:0] offset_low_r;
  logic signed [31:0] sample_r;
  logic               kind_r;

  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  logic               out_kind_r;
  logic               out_sat_r;

  logic               in_fire;
  logic               spread;
  logic               div_start;
  logic               div_done;
  logic [QW-1:0]      div_quo;
  logic [WW-1:0]      quo_wide;
  logic               mul_start;
  logic signed [32:0] mul_diff;
  mmcs_mul_rsp_t      mul_rsp;
  logic               push;
  logic               out_free;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign spread   = high_r > low_r;
  assign out_free = !out_valid_r || out_chan.ready;
  assign quo_wide = WW'(div_quo);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.command == CMD_FINISH) begin
            state_nxt = spread ? ST_DIV : ST_MST;
          end else if (in_chan.command == CMD_CONVERT) begin
            state_nxt = ST_MST;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_MST;
        end
      end
      ST_MST: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (mul_rsp.done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_chan.ready = state_r == ST_IDLE;
    div_start     = in_fire && (in_chan.command == CMD_FINISH) && spread;
    mul_start     = state_r == ST_MST;
    push          = (state_r == ST_PUSH) && out_free;
    if (kind_r == KIND_OFFSET) begin
      mul_diff = 33'sd0 - {offset_low_r[31], offset_low_r};
    end else begin
      mul_diff = {sample_r[31], sample_r} - {offset_low_r[31], offset_low_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      full_scale_r <= FS_RESET;
      low_r        <= EXT_POS;
      high_r       <= EXT_NEG;
      gain_r       <= GAIN_RESET;
      offset_low_r <= EXT_POS;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        full_scale_r <= cfg_wdata;
      end
      if (in_fire && (in_chan.command == CMD_OBSERVE)) begin
        if (in_chan.sample < low_r) begin
          low_r <= in_chan.sample;
        end
        if (in_chan.sample > high_r) begin
          high_r <= in_chan.sample;
        end
      end
      if (in_fire && (in_chan.command == CMD_FINISH)) begin
        // The low is latched for later conversions and the extremes re-armed.
        offset_low_r <= low_r;
        low_r        <= EXT_POS;
        high_r       <= EXT_NEG;
        if (!spread) begin
          gain_r <= GAIN_W'(full_scale_r) << FRAC_BITS;
        end
      end
      if (div_done) begin
        gain_r <= (quo_wide > WW'(GAIN_MAX)) ? GAIN_MAX : quo_wide[GAIN_W-1:0];
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_chan.sample;
      kind_r   <= (in_chan.command == CMD_FINISH) ? KIND_OFFSET : KIND_SAMPLE;
    end
    if (push) begin
      out_value_r <= mul_rsp.value;
      out_kind_r  <= kind_r;
      out_sat_r   <= mul_rsp.sat;
    end
  end

  mmcs_div #(
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (QW'(full_scale_r) << (2 * FRAC_BITS)),
    .divisor  (32'(high_r - low_r)),
    .done     (div_done),
    .quotient (div_quo)
  );

  mmcs_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .gain  (gain_r),
    .diff  (mul_diff),
    .rsp   (mul_rsp)
  );

  assign out_chan.valid     = out_valid_r;
  assign out_chan.value     = out_value_r;
  assign out_chan.kind      = out_kind_r;
  assign out_chan.saturated = out_sat_r;

endmodule

// ===== design/mmcs_checker.sv =====
// Port-level checks for the contrast stretch block, bound to the top level.
module mmcs_checker
  import mmcs_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        out_kind,
  input logic        out_saturated
);

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  // Coming out of reset the block is ready and holds no result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // An observe transfer is absorbed at once.
  a_observe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_command == CMD_OBSERVE) |=> in_ready)
    else $error("block busy after an observe transfer");

  // Finish and convert transfers occupy the shared units.
  a_work_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_command == CMD_FINISH || in_command == CMD_CONVERT)) |=> !in_ready)
    else $error("block ready while a finish or convert is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_value) && $stable(out_kind) && $stable(out_saturated)))
    else $error("result changed or dropped while stalled");

endmodule

bind min_max_contrast_stretch mmcs_checker u_mmcs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .in_command    (in_chan.command),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_value     (out_chan.value),
  .out_kind      (out_chan.kind),
  .out_saturated (out_chan.saturated)
);
